// ===== hw/rtl/klt_pkg.sv =====
// klt_pkg: shared types, codes and key tables for the keyboard latch translator
// no dependencies; imported by the rtl modules and the checker

package klt_pkg;

	typedef enum logic [2:0] {
		KIND_CHAR_PRESS    = 3'd0,
		KIND_SPECIAL_PRESS = 3'd1,
		KIND_READ_DATA     = 3'd2,
		KIND_READ_FLAG     = 3'd3,
		KIND_CAPS_TOGGLE   = 3'd4,
		KIND_TAKE_COUNT    = 3'd5,
		KIND_SOFT_RESET    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		SPECIAL_LEFT   = 3'd0,
		SPECIAL_UP     = 3'd1,
		SPECIAL_RIGHT  = 3'd2,
		SPECIAL_DOWN   = 3'd3,
		SPECIAL_DELETE = 3'd4
	} special_t;

	localparam int unsigned CODE_W  = 7;
	localparam int unsigned COUNT_W = 32;

	localparam logic [CODE_W-1:0] CASE_OFFSET = 7'd32;
	localparam logic [CODE_W-1:0] UPPER_START = 7'h60;
	localparam logic [CODE_W-1:0] LOWER_A     = 7'h61;
	localparam logic [CODE_W-1:0] LOWER_Z     = 7'h7A;
	localparam logic [CODE_W-1:0] BACKSLASH   = 7'h5C;
	localparam logic [CODE_W-1:0] LBRACKET    = 7'h5B;
	localparam logic [CODE_W-1:0] RBRACKET    = 7'h5D;
	localparam logic [CODE_W-1:0] RETURN_KEY  = 7'h0D;
	localparam logic [CODE_W-1:0] CTRL_BSLASH = 7'd28;
	localparam logic [CODE_W-1:0] CTRL_LBRACK = 7'd27;
	localparam logic [CODE_W-1:0] CTRL_RBRACK = 7'd29;
	localparam logic [CODE_W-1:0] CTRL_RETURN = 7'h0A;

	// modifier and model controls handed to the translator
	typedef struct packed {
		logic shift;
		logic ctrl;
		logic caps_lock;
		logic original_model;
	} mods_t;

	// shifted form of a digit or punctuation key; bit 7 flags a table hit
	function automatic logic [CODE_W:0] shifted_key(input logic [CODE_W-1:0] key);
		logic [CODE_W:0] r;
		r = {1'b0, key};
		case (key)
			7'h31:   r = {1'b1, 7'h21};
			7'h32:   r = {1'b1, 7'h40};
			7'h33:   r = {1'b1, 7'h23};
			7'h34:   r = {1'b1, 7'h24};
			7'h35:   r = {1'b1, 7'h25};
			7'h36:   r = {1'b1, 7'h5E};
			7'h37:   r = {1'b1, 7'h26};
			7'h38:   r = {1'b1, 7'h2A};
			7'h39:   r = {1'b1, 7'h28};
			7'h30:   r = {1'b1, 7'h29};
			7'h60:   r = {1'b1, 7'h7E};
			7'h2D:   r = {1'b1, 7'h5F};
			7'h3D:   r = {1'b1, 7'h2B};
			7'h5C:   r = {1'b1, 7'h7C};
			7'h5B:   r = {1'b1, 7'h7B};
			7'h5D:   r = {1'b1, 7'h7D};
			7'h3B:   r = {1'b1, 7'h3A};
			7'h27:   r = {1'b1, 7'h22};
			7'h2C:   r = {1'b1, 7'h3C};
			7'h2E:   r = {1'b1, 7'h3E};
			7'h2F:   r = {1'b1, 7'h3F};
			default: r = {1'b0, key};
		endcase
		return r;
	endfunction

	// arrow and delete codes per model
	function automatic logic [CODE_W-1:0] special_code(input special_t sel, input logic orig);
		logic [CODE_W-1:0] r;
		r = '0;
		case (sel)
			SPECIAL_LEFT:   r = 7'h08;
			SPECIAL_UP:     r = orig ? 7'h0D : 7'h0B;
			SPECIAL_RIGHT:  r = 7'h15;
			SPECIAL_DOWN:   r = orig ? 7'h2F : 7'h0A;
			SPECIAL_DELETE: r = orig ? 7'h00 : 7'h7F;
			default:        r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/klt_translate.sv =====
// klt_translate: combinational key translation (modifiers, case, special keys)
// depends on klt_pkg

module klt_translate
	import klt_pkg::*;
(
	input  logic [7:0]        key_value,
	input  mods_t             mods,
	output logic              char_valid,
	output logic [CODE_W-1:0] char_code,
	output logic              special_valid,
	output logic [CODE_W-1:0] special_out
);

	logic [CODE_W-1:0] key7;
	logic [CODE_W:0]   shift_hit;
	logic [CODE_W-1:0] mod_code;
	logic              is_lower;

	assign key7       = key_value[CODE_W-1:0];
	assign char_valid = ~key_value[7];
	assign shift_hit  = shifted_key(key7);

	// shift wins over ctrl
	always_comb begin
		mod_code = key7;
		if (mods.shift) begin
			mod_code = shift_hit[CODE_W-1:0];
		end else if (mods.ctrl) begin
			if (key7 >= LOWER_A && key7 <= LOWER_Z) begin
				mod_code = key7 - (LOWER_A - 7'd1);
			end else if (key7 == BACKSLASH) begin
				mod_code = CTRL_BSLASH;
			end else if (key7 == LBRACKET) begin
				mod_code = CTRL_LBRACK;
			end else if (key7 == RBRACKET) begin
				mod_code = CTRL_RBRACK;
			end else if (key7 == RETURN_KEY) begin
				mod_code = CTRL_RETURN;
			end
		end
	end

	assign is_lower = (mod_code >= LOWER_A) && (mod_code <= LOWER_Z);

	always_comb begin
		char_code = mod_code;
		if (mods.original_model) begin
			if (mod_code >= UPPER_START) begin
				char_code = mod_code - CASE_OFFSET;
			end
		end else if (mods.caps_lock && is_lower) begin
			char_code = mod_code - CASE_OFFSET;
		end
	end

	assign special_valid = (key_value < 8'd5);
	assign special_out   = special_code(special_t'(key_value[2:0]), mods.original_model);

endmodule

// ===== hw/rtl/keyboard_latch_translator.sv =====
// keyboard_latch_translator: top level of the keyboard data/strobe latch
// depends on klt_pkg and klt_translate

// Keyboard latch with key translation. Each request on the input channel is a
// key event or a bus access; each produces exactly one result request. Requests
// go through an input register, then one short pass of translation and state
// update into the result register; a new request is taken every cycle as long
// as results are being taken, and only the result register can hold the input
// side back. Char presses are mapped by shift (21 digit/punctuation keys), then
// ctrl (a-z to 1-26 and four control codes), then caps lock (later model) or
// uppercase-from-0x60 (original model), and latched with the strobe set; arrow
// and delete keys use a per-model table. Read data returns the code with the
// strobe in bit 7, read flag returns the code with key_still_down in bit 7 and
// clears the strobe. Both reads bump a saturating 32-bit counter that take
// count returns and clears. The model select register is written through the
// cfg channel, always ready; users must write it only while idle, unenforced.

module keyboard_latch_translator
	import klt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// config write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               original_model,
	// input requests
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [7:0]         key_value,
	input  logic               shift_held,
	input  logic               ctrl_held,
	input  logic               key_still_down,
	// result requests
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         read_byte,
	output logic [CODE_W-1:0]  latched_code,
	output logic [COUNT_W-1:0] query_count
);

	// config and architectural state
	logic               orig_model_q;
	logic [CODE_W-1:0]  code_q;
	logic               strobe_q;
	logic               caps_lock_q;
	logic [COUNT_W-1:0] count_q;

	// input stage
	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic [7:0]         key_s1;
	logic               shift_s1;
	logic               ctrl_s1;
	logic               held_s1;

	// result stage
	logic               out_valid_q;
	logic [7:0]         read_byte_q;
	logic [CODE_W-1:0]  code_out_q;
	logic [COUNT_W-1:0] count_out_q;

	logic               advance;
	mods_t              mods;
	logic               char_valid;
	logic [CODE_W-1:0]  char_code;
	logic               special_valid;
	logic [CODE_W-1:0]  special_out;

	logic [CODE_W-1:0]  code_next;
	logic               strobe_next;
	logic               caps_next;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] count_report;
	logic [7:0]         rbyte_next;
	logic [COUNT_W-1:0] count_inc;

	assign cfg_ready = 1'b1;

	// s1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_model_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			orig_model_q <= original_model;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			key_s1   <= key_value;
			shift_s1 <= shift_held;
			ctrl_s1  <= ctrl_held;
			held_s1  <= key_still_down;
		end
	end

	assign mods = '{
		shift:          shift_s1,
		ctrl:           ctrl_s1,
		caps_lock:      caps_lock_q,
		original_model: orig_model_q
	};

	klt_translate u_translate (
		.key_value     (key_s1),
		.mods          (mods),
		.char_valid    (char_valid),
		.char_code     (char_code),
		.special_valid (special_valid),
		.special_out   (special_out)
	);

	// saturating read counter increment
	assign count_inc = (count_q == {COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;

	// next state and result for the request in s1
	always_comb begin
		code_next    = code_q;
		strobe_next  = strobe_q;
		caps_next    = caps_lock_q;
		count_next   = count_q;
		rbyte_next   = 8'd0;
		case (kind_t'(kind_s1))
			KIND_CHAR_PRESS: begin
				if (char_valid) begin
					code_next   = char_code;
					strobe_next = 1'b1;
				end
			end
			KIND_SPECIAL_PRESS: begin
				if (special_valid) begin
					code_next   = special_out;
					strobe_next = 1'b1;
				end
			end
			KIND_READ_DATA: begin
				count_next = count_inc;
				rbyte_next = {strobe_q, code_q};
			end
			KIND_READ_FLAG: begin
				count_next  = count_inc;
				strobe_next = 1'b0;
				rbyte_next  = {held_s1, code_q};
			end
			KIND_CAPS_TOGGLE: begin
				// caps toggling only exists on the later model
				if (!orig_model_q) begin
					caps_next = ~caps_lock_q;
				end
			end
			KIND_TAKE_COUNT: begin
				count_next = '0;
			end
			KIND_SOFT_RESET: begin
				strobe_next = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// take count reports the value before clearing, others the updated count
	assign count_report = (kind_t'(kind_s1) == KIND_TAKE_COUNT) ? count_q : count_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= '0;
			strobe_q    <= 1'b0;
			caps_lock_q <= 1'b1;
			count_q     <= '0;
		end else if (advance) begin
			code_q      <= code_next;
			strobe_q    <= strobe_next;
			caps_lock_q <= caps_next;
			count_q     <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_byte_q <= rbyte_next;
			code_out_q  <= code_next;
			count_out_q <= count_report;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_byte    = read_byte_q;
	assign latched_code = code_out_q;
	assign query_count  = count_out_q;

endmodule

// ===== hw/rtl/klt_checker.sv =====
// klt_checker: port-level assertions for keyboard_latch_translator
// depends on klt_pkg; bound to the top level below

module klt_checker
	import klt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         read_byte,
	input logic [CODE_W-1:0]  latched_code
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// the input side only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a stalled result");

	// a read returns the latched code, which reads never change
	a_read_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_byte != 8'd0 |-> read_byte[CODE_W-1:0] == latched_code)
		else $error("read byte disagrees with latched code");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind keyboard_latch_translator klt_checker u_klt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_byte    (read_byte),
	.latched_code (latched_code)
);
